### src/lbl2u8_pkg.sv
// Shared types, byte codes and a helper function for the label to UTF-8 cleaner.
package lbl2u8_pkg;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NUL  = 8'h00;

  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [5:0] UTF8_LOW6 = 6'h3F;

  // Up to three bytes come from one request.
  typedef struct packed {
    logic [2:0][7:0] bytes;  // bytes[0] goes out first
    logic [1:0]      cnt;    // number of results, 1 to 3 when loaded
    logic            mark;   // empty end marker, byte not valid
    logic            last;   // group closes the label
  } group_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage

### src/lbl2u8_decode.sv
// Parser state and combinational decode of one label byte into a result group.
module lbl2u8_decode (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           item_byte,
  input  logic                 item_last,
  input  logic                 take,
  output logic                 emit,
  output lbl2u8_pkg::group_t   grp
);
  import lbl2u8_pkg::*;

  typedef enum logic [1:0] {
    MODE_TEXT = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SKIP = 2'd2
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  dcnt_r, dcnt_nxt;
  logic [11:0] acc_r, acc_nxt;
  hex_t        hx;
  logic [15:0] cp;

  assign hx = hex_decode(item_byte);
  assign cp = {acc_r, hx.val};

  always_comb begin
    mode_nxt  = mode_r;
    dcnt_nxt  = dcnt_r;
    acc_nxt   = acc_r;
    grp.bytes = '0;
    grp.cnt   = 2'd0;
    grp.mark  = 1'b0;
    grp.last  = item_last;
    unique case (mode_r)
      MODE_SKIP: begin
      end
      MODE_ESC: begin
        if (item_byte == CH_HASH) begin
          grp.bytes[0] = CH_HASH;
          grp.cnt      = 2'd1;
          mode_nxt     = MODE_TEXT;
        end else if (!hx.ok) begin
          mode_nxt = MODE_TEXT;
        end else if (dcnt_r == 2'd3) begin
          mode_nxt = MODE_TEXT;
          if (cp == 16'd0) begin
            grp.cnt = 2'd0;
          end else if (cp[15:7] == 9'd0) begin
            grp.bytes[0] = cp[7:0];
            grp.cnt      = 2'd1;
          end else if (cp[15:11] == 5'd0) begin
            grp.bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
            grp.bytes[1] = UTF8_CONT | {2'd0, cp[5:0] & UTF8_LOW6};
            grp.cnt      = 2'd2;
          end else begin
            grp.bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
            grp.bytes[1] = UTF8_CONT | {2'd0, cp[11:6]};
            grp.bytes[2] = UTF8_CONT | {2'd0, cp[5:0] & UTF8_LOW6};
            grp.cnt      = 2'd3;
          end
        end else begin
          acc_nxt  = {acc_r[7:0], hx.val};
          dcnt_nxt = dcnt_r + 2'd1;
        end
      end
      default: begin
        if (item_byte == CH_AMP) begin
        end else if (item_byte == CH_TAB) begin
          mode_nxt = MODE_SKIP;
        end else if (item_byte == CH_HASH) begin
          mode_nxt = MODE_ESC;
          dcnt_nxt = 2'd0;
          acc_nxt  = 12'd0;
        end else if (item_byte != CH_NUL) begin
          grp.bytes[0] = item_byte;
          grp.cnt      = 2'd1;
        end
      end
    endcase
    if (item_last) begin
      if (grp.cnt == 2'd0) begin
        grp.mark = 1'b1;
        grp.cnt  = 2'd1;
      end
      mode_nxt = MODE_TEXT;
      dcnt_nxt = 2'd0;
      acc_nxt  = 12'd0;
    end
  end

  assign emit = (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TEXT;
      dcnt_r <= 2'd0;
      acc_r  <= 12'd0;
    end else if (take) begin
      mode_r <= mode_nxt;
      dcnt_r <= dcnt_nxt;
      acc_r  <= acc_nxt;
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && item_last |=> mode_r == MODE_TEXT && dcnt_r == 2'd0 && acc_r == 12'd0)
    else $error("parser state not cleared after end of label");
  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    take && item_last |-> emit)
    else $error("end of label produced no result");
  a_mark_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    grp.mark |-> item_last && grp.cnt == 2'd1)
    else $error("end marker outside end of label");
`endif

endmodule

### src/lbl2u8_outq.sv
// Result group buffer that hands out one byte of the group per accepted result.
module lbl2u8_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  lbl2u8_pkg::group_t   grp_in,
  output logic                 load_ok,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_byte_valid,
  output logic                 out_run_last,
  output logic                 out_label_end
);
  import lbl2u8_pkg::*;

  group_t     grp_r;
  logic       grp_v_r;
  logic [1:0] idx_r;
  logic       pop;

  assign out_valid      = grp_v_r;
  assign out_run_last   = (idx_r == grp_r.cnt - 2'd1);
  assign out_label_end  = out_run_last && grp_r.last;
  assign out_byte_valid = !grp_r.mark;
  assign pop            = grp_v_r && out_ready;
  // A new group may enter while the final byte of the current one leaves.
  assign load_ok        = !grp_v_r || (pop && out_run_last);

  always_comb begin
    case (idx_r)
      2'd0:    out_byte = grp_r.bytes[0];
      2'd1:    out_byte = grp_r.bytes[1];
      2'd2:    out_byte = grp_r.bytes[2];
      default: out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      grp_v_r <= 1'b1;
      idx_r   <= 2'd0;
    end else if (pop) begin
      if (out_run_last) begin
        grp_v_r <= 1'b0;
        idx_r   <= 2'd0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

`ifndef SYNTHESIS
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    grp_v_r |-> grp_r.cnt != 2'd0)
    else $error("empty group held in result buffer");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    grp_v_r |-> idx_r < grp_r.cnt)
    else $error("result index beyond group");
  a_mid_stays: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !out_run_last |=> grp_v_r)
    else $error("group dropped before its last byte");
  a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> load_ok)
    else $error("group overwritten before done");
`endif

endmodule

### src/label_escape_to_utf8.sv
// Top level of the menu label cleaner: input register, decoder and result buffer.
//
//  channel | ports                                             | carries
//  --------+---------------------------------------------------+---------------------------
//  in      | in_valid, in_ready, in_label_byte, in_label_last   | one coded label byte
//  out     | out_valid, out_ready, out_byte, out_byte_valid,    | one cleaned UTF-8 byte or
//          | out_run_last, out_label_end                        | an empty end marker
//
// One request is taken per cycle while each request yields at most one result
// and out_ready is high. A request that yields two or three results (a finished
// escape) holds the next one in the input register until its last byte leaves, as
// the result port moves one byte per cycle. The input register is freed whenever its
// request is decoded, so in_ready does not wait for the result buffer to empty.
// Reset (rst_n low at a clock edge) empties both registers and puts the parser
// back into plain text mode.
module label_escape_to_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_label_byte,
  input  logic       in_label_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_run_last,
  output logic       out_label_end
);
  import lbl2u8_pkg::*;

  // Input register holding the request under decode.
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       in_v_r;

  group_t grp;
  logic   emit;
  logic   load_ok;
  logic   advance;

  // The held request leaves when it produces no result, or when the result
  // buffer can take its group in this cycle.
  assign advance  = in_v_r && (!emit || load_ok);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_label_byte;
      in_last_r <= in_label_last;
    end
  end

  // Parser: escape, skip and text handling plus UTF-8 encoding of code points.
  lbl2u8_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_byte (in_byte_r),
    .item_last (in_last_r),
    .take      (advance),
    .emit      (emit),
    .grp       (grp)
  );

  // Result buffer: hands out the group one byte per accepted result.
  lbl2u8_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && emit),
    .grp_in         (grp),
    .load_ok        (load_ok),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_label_end  (out_label_end)
  );

endmodule
